// File: rtl/core/mcf_pkg.sv
// shared types and constants for the motor command channel with failsafe
package mcf_pkg;

    localparam logic [1:0] OP_SET_SPEED = 2'd0;
    localparam logic [1:0] OP_STOP      = 2'd1;
    localparam logic [1:0] OP_TICK      = 2'd2;

    localparam logic [1:0] KIND_SERVO   = 2'd0;
    localparam logic [1:0] KIND_HBRIDGE = 2'd1;

    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_SERVO   = 2'd1;
    localparam logic [1:0] ACT_HBRIDGE = 2'd2;

    localparam logic [2:0] REG_MOTOR_KIND   = 3'd0;
    localparam logic [2:0] REG_INVERT_DIR   = 3'd1;
    localparam logic [2:0] REG_SPEED_CAP    = 3'd2;
    localparam logic [2:0] REG_PULSE_MIN    = 3'd3;
    localparam logic [2:0] REG_PULSE_MAX    = 3'd4;
    localparam logic [2:0] REG_PULSE_NEUTRAL = 3'd5;
    localparam logic [2:0] REG_TIMEOUT      = 3'd6;
    localparam logic [2:0] REG_BRAKE_ON     = 3'd7;

    localparam logic [2:0] MODE_NONE    = 3'd0;
    localparam logic [2:0] MODE_REFUSE  = 3'd1;
    localparam logic [2:0] MODE_STOP    = 3'd2;
    localparam logic [2:0] MODE_SERVO   = 3'd3;
    localparam logic [2:0] MODE_HBRIDGE = 3'd4;

    localparam logic [12:0] FULL_SPEED = 13'd4096;
    localparam logic signed [23:0] CAP_SCALE = 24'sd100;

    // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for x below 2^31
    localparam logic [31:0] RECIP_100   = 32'd2748779070;
    localparam int          RECIP_SHIFT = 38;

    localparam logic [15:0] PULSE_MIN_RESET     = 16'd1000;
    localparam logic [15:0] PULSE_MAX_RESET     = 16'd2000;
    localparam logic [15:0] PULSE_NEUTRAL_RESET = 16'd1500;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] speed;
        logic [31:0]        time_ms;
    } mcf_in_t;

    typedef struct packed {
        logic        status;
        logic [1:0]  action;
        logic [15:0] pulse_us;
        logic        dir_forward;
        logic        brake;
        logic [12:0] duty;
        logic        timed_out;
    } mcf_out_t;

endpackage

// File: rtl/core/motor_command_with_failsafe_top.sv
// motor command channel: servo pulse or h-bridge drive with a failsafe watchdog
//
// One transaction in gives one transaction out. The block takes a new input
// in every cycle unless in_stall is high; a result passes through the input
// register, product register and result register in turn, a depth set by the
// servo path of a speed-times-span multiply followed by a reciprocal multiply
// for the divide by 100 of the capped offset. Stages advance independently,
// so a bubble is filled while a result waits on out_stall. The watchdog
// compares the millisecond time of each tick with the time of the last
// command or timeout stop, held in one register updated in input order.
// Configuration writes are always taken (cfg_ready is held high) and must only
// arrive while the block is idle.
module motor_command_with_failsafe_top
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  mcf_pkg::mcf_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output mcf_pkg::mcf_out_t out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data
);
    import mcf_pkg::*;

    logic [1:0]  motor_kind_reg;
    logic        invert_dir_reg;
    logic [15:0] speed_cap_reg;
    logic [15:0] pulse_min_reg;
    logic [15:0] pulse_max_reg;
    logic [15:0] pulse_neutral_reg;
    logic [31:0] timeout_reg;
    logic        brake_on_reg;
    logic [31:0] last_time_reg;

    logic     a_valid_reg;
    mcf_in_t  a_data_reg;

    logic        b_valid_reg;
    logic [2:0]  b_mode_reg;
    logic        b_timed_out_reg;
    logic        b_neg_reg;
    logic        b_use_cap_reg;
    logic [31:0] b_prod_speed_reg;
    logic [30:0] b_prod_cap_reg;
    logic        b_dir_reg;
    logic [12:0] b_duty_reg;

    logic     out_valid_reg;
    mcf_out_t out_data_reg;

    logic en_out;
    logic en_b;
    logic en_a;

    // stage a
    logic signed [16:0] s_a;
    logic [16:0]        mag_a;
    logic [15:0]        diff_a;
    logic [14:0]        span_a;
    logic [31:0]        prod_speed_a;
    logic [30:0]        prod_cap_a;
    logic signed [23:0] speed100_a;
    logic signed [29:0] speed100_ext_a;
    logic signed [29:0] cap_scaled_a;
    logic               cap_hi_a;
    logic               cap_lo_a;
    logic               neg_a;
    logic [12:0]        duty_a;
    logic [31:0]        elapsed_a;
    logic               tick_to_a;
    logic [2:0]         mode_a;
    logic               update_time_a;

    // stage b
    logic [62:0]        recip_prod_b;
    logic [24:0]        delta_b;
    logic signed [26:0] us_b;
    logic signed [26:0] us_lo_b;
    logic signed [26:0] us_clamped_b;
    mcf_out_t           result_b;

    assign en_out    = !out_valid_reg || !out_stall;
    assign en_b      = !b_valid_reg || en_out;
    assign en_a      = !a_valid_reg || en_b;
    assign in_stall  = !en_a;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motor_kind_reg    <= KIND_SERVO;
            invert_dir_reg    <= 1'b0;
            speed_cap_reg     <= '0;
            pulse_min_reg     <= PULSE_MIN_RESET;
            pulse_max_reg     <= PULSE_MAX_RESET;
            pulse_neutral_reg <= PULSE_NEUTRAL_RESET;
            timeout_reg       <= '0;
            brake_on_reg      <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MOTOR_KIND:    motor_kind_reg    <= cfg_data[1:0];
                REG_INVERT_DIR:    invert_dir_reg    <= cfg_data[0];
                REG_SPEED_CAP:     speed_cap_reg     <= cfg_data[15:0];
                REG_PULSE_MIN:     pulse_min_reg     <= cfg_data[15:0];
                REG_PULSE_MAX:     pulse_max_reg     <= cfg_data[15:0];
                REG_PULSE_NEUTRAL: pulse_neutral_reg <= cfg_data[15:0];
                REG_TIMEOUT:       timeout_reg       <= cfg_data;
                REG_BRAKE_ON:      brake_on_reg      <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        s_a = {a_data_reg.speed[15], a_data_reg.speed};
        if (invert_dir_reg)
        begin
            s_a = -s_a;
        end
        mag_a  = s_a[16] ? 17'(-s_a) : 17'(s_a);
        diff_a = pulse_max_reg - pulse_min_reg;
        span_a = (pulse_max_reg >= pulse_min_reg) ? diff_a[15:1] : '0;

        prod_speed_a = {15'b0, mag_a} * {17'b0, span_a};
        prod_cap_a   = {15'b0, speed_cap_reg} * {16'b0, span_a};

        speed100_a     = $signed({{7{s_a[16]}}, s_a}) * CAP_SCALE;
        speed100_ext_a = {{6{speed100_a[23]}}, speed100_a};
        cap_scaled_a   = $signed({2'b00, speed_cap_reg, 12'b0});
        cap_hi_a = (speed_cap_reg != '0) && (speed100_ext_a > cap_scaled_a);
        cap_lo_a = (speed_cap_reg != '0) && (speed100_ext_a < -cap_scaled_a);
        neg_a    = cap_hi_a ? 1'b0 : (cap_lo_a ? 1'b1 : s_a[16]);

        duty_a = (mag_a > {4'b0, FULL_SPEED}) ? FULL_SPEED : mag_a[12:0];

        elapsed_a = a_data_reg.time_ms - last_time_reg;
        tick_to_a = (timeout_reg != '0) && (elapsed_a > timeout_reg);

        mode_a        = MODE_NONE;
        update_time_a = 1'b0;
        unique case (a_data_reg.op)
            OP_SET_SPEED:
            begin
                if (motor_kind_reg == KIND_SERVO)
                begin
                    mode_a        = MODE_SERVO;
                    update_time_a = 1'b1;
                end
                else if (motor_kind_reg == KIND_HBRIDGE)
                begin
                    mode_a        = MODE_HBRIDGE;
                    update_time_a = 1'b1;
                end
                else
                begin
                    mode_a = MODE_REFUSE;
                end
            end
            OP_STOP:
            begin
                mode_a        = MODE_STOP;
                update_time_a = 1'b1;
            end
            OP_TICK:
            begin
                if (tick_to_a)
                begin
                    mode_a        = MODE_STOP;
                    update_time_a = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // input register and command time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            last_time_reg <= '0;
        end
        else
        begin
            if (en_a)
            begin
                a_valid_reg <= in_valid;
            end
            if (a_valid_reg && en_b && update_time_a)
            begin
                last_time_reg <= a_data_reg.time_ms;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a && in_valid)
        begin
            a_data_reg <= in_data;
        end
    end

    // product register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (en_b)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_b && a_valid_reg)
        begin
            b_mode_reg       <= mode_a;
            b_timed_out_reg  <= (a_data_reg.op == OP_TICK) && tick_to_a;
            b_neg_reg        <= neg_a;
            b_use_cap_reg    <= cap_hi_a || cap_lo_a;
            b_prod_speed_reg <= prod_speed_a;
            b_prod_cap_reg   <= prod_cap_a;
            b_dir_reg        <= !s_a[16];
            b_duty_reg       <= duty_a;
        end
    end

    always_comb
    begin
        recip_prod_b = 63'(b_prod_cap_reg) * 63'(RECIP_100);
        delta_b      = b_use_cap_reg ? recip_prod_b[62:RECIP_SHIFT]
                                     : {5'b0, b_prod_speed_reg[31:12]};
        us_b = b_neg_reg ? $signed({11'b0, pulse_neutral_reg}) - $signed({2'b0, delta_b})
                         : $signed({11'b0, pulse_neutral_reg}) + $signed({2'b0, delta_b});
        us_lo_b = (us_b < $signed({11'b0, pulse_min_reg})) ?
                  $signed({11'b0, pulse_min_reg}) : us_b;
        us_clamped_b = (us_lo_b > $signed({11'b0, pulse_max_reg})) ?
                       $signed({11'b0, pulse_max_reg}) : us_lo_b;

        result_b           = '0;
        result_b.timed_out = b_timed_out_reg;
        case (b_mode_reg)
            MODE_REFUSE:
            begin
                result_b.status = 1'b1;
            end
            MODE_STOP:
            begin
                if (motor_kind_reg == KIND_SERVO && pulse_neutral_reg != '0)
                begin
                    result_b.action   = ACT_SERVO;
                    result_b.pulse_us = pulse_neutral_reg;
                end
                else if (motor_kind_reg == KIND_HBRIDGE)
                begin
                    result_b.action      = ACT_HBRIDGE;
                    result_b.dir_forward = 1'b1;
                end
            end
            MODE_SERVO:
            begin
                result_b.action   = ACT_SERVO;
                result_b.pulse_us = us_clamped_b[15:0];
            end
            MODE_HBRIDGE:
            begin
                result_b.action      = ACT_HBRIDGE;
                result_b.dir_forward = b_dir_reg;
                result_b.brake       = brake_on_reg;
                result_b.duty        = b_duty_reg;
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en_out)
        begin
            out_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_out && b_valid_reg)
        begin
            out_data_reg <= result_b;
        end
    end

endmodule
